// File: src/bfm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter membership package
// Word types, action and register codes, hash constants and helpers.
// ---------------------------------------------------------------------------
package bfm_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CHECK  = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 17;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_BITS = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT  = 4'd1;

	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned BIT_SEL_W = 6;

	localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
	localparam logic [63:0] FMIX_1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] MM_ADD1 = 64'h0000000052dce729;
	localparam logic [63:0] MM_ADD2 = 64'h0000000038495ab5;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic [4:0]  key_len;
	} cmd_t;

	typedef struct packed {
		logic        answer;
		logic [31:0] insert_total;
		logic [31:0] query_total;
	} res_t;

	typedef struct packed {
		logic       start;
		logic       first;
		logic [4:0] seed;
	} hash_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] pos;
	} hash_resp_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
		return (v << r) | (v >> (64 - r));
	endfunction

	function automatic logic [63:0] xs33(input logic [63:0] v);
		return v ^ (v >> 33);
	endfunction

endpackage
`default_nettype wire

// File: src/bfm_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter word queue
// Small first-in first-out queue of words with full and empty flags.
// ---------------------------------------------------------------------------
module bfm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/bfm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter front end
// Accept words, clip the key length, drop unused key bytes and queue them.
// ---------------------------------------------------------------------------
module bfm_front #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         hold,
	input  wire logic         push,
	output logic              full,
	input  wire logic [1:0]   action,
	input  wire logic [63:0]  key_bytes_low,
	input  wire logic [63:0]  key_bytes_high,
	input  wire logic [4:0]   key_length,
	input  wire logic         cmd_pop,
	output logic              cmd_empty,
	output bfm_pkg::cmd_t     cmd
);
	localparam logic [4:0] MAXK = 5'(MAX_KEY_BYTES);

	bfm_pkg::cmd_t cmd_in;
	logic [4:0]    len_c;
	logic          q_full;
	logic [$bits(bfm_pkg::cmd_t)-1:0] q_rdata;

	always_comb begin
		len_c = (key_length > MAXK) ? MAXK : key_length;
		cmd_in.action  = action;
		cmd_in.key_len = len_c;
		for (int i = 0; i < 8; i++) begin
			cmd_in.key_lo[8*i +: 8] = (5'(i) < len_c) ? key_bytes_low[8*i +: 8] : 8'h00;
			cmd_in.key_hi[8*i +: 8] = (5'(i + 8) < len_c) ? key_bytes_high[8*i +: 8] : 8'h00;
		end
	end

	assign full = q_full || hold;
	assign cmd  = bfm_pkg::cmd_t'(q_rdata);

	bfm_fifo #(
		.WIDTH($bits(bfm_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !hold),
		.wdata (cmd_in),
		.full  (q_full),
		.pop   (cmd_pop),
		.rdata (q_rdata),
		.empty (cmd_empty)
	);

endmodule
`default_nettype wire

// File: src/bfm_hash.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter hash unit
// Seeded MurmurHash3 x64_128 low word on a shared 32x32 multiplier,
// reduced modulo the filter size four bits a cycle.
// ---------------------------------------------------------------------------
module bfm_hash (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bfm_pkg::hash_req_t req,
	input  wire logic [63:0]       key_lo,
	input  wire logic [63:0]       key_hi,
	input  wire logic [4:0]        key_len,
	input  wire logic [16:0]       modulus,
	output bfm_pkg::hash_resp_t    resp
);
	localparam logic [4:0] H_IDLE = 5'd0;
	localparam logic [4:0] H_MUL  = 5'd1;
	localparam logic [4:0] H_A1   = 5'd2;
	localparam logic [4:0] H_A2   = 5'd3;
	localparam logic [4:0] H_A3   = 5'd4;
	localparam logic [4:0] H_A4   = 5'd5;
	localparam logic [4:0] H_I0   = 5'd6;
	localparam logic [4:0] H_I1   = 5'd7;
	localparam logic [4:0] H_I2   = 5'd8;
	localparam logic [4:0] H_I3   = 5'd9;
	localparam logic [4:0] H_F0   = 5'd10;
	localparam logic [4:0] H_F1   = 5'd11;
	localparam logic [4:0] H_F2   = 5'd12;
	localparam logic [4:0] H_F3   = 5'd13;
	localparam logic [4:0] H_F4   = 5'd14;
	localparam logic [4:0] H_F5   = 5'd15;
	localparam logic [4:0] H_DIV  = 5'd16;

	logic [4:0]  st_q, ret_q;
	logic [1:0]  mph_q;
	logic [3:0]  dcnt_q;
	logic [63:0] v_q, acc_q, mc_q, m1_q, m2_q, h1_q, h2_q;
	logic [4:0]  seed_q;
	logic [16:0] rem_q, rem_n;
	logic        done_q;
	logic [31:0] mul_x, mul_y;
	logic [63:0] prod, seed64, len64;
	logic        long_key;
	logic [17:0] t;

	assign mul_x    = (mph_q == 2'd2) ? v_q[63:32] : v_q[31:0];
	assign mul_y    = (mph_q == 2'd1) ? mc_q[63:32] : mc_q[31:0];
	assign prod     = mul_x * mul_y;
	assign seed64   = {59'd0, seed_q};
	assign len64    = {59'd0, key_len};
	assign long_key = (key_len >= 5'd16);

	always_comb begin
		rem_n = rem_q;
		t     = '0;
		for (int j = 0; j < 4; j++) begin
			t = {rem_n, v_q[63 - j]};
			if (t >= {1'b0, modulus}) begin
				t = t - {1'b0, modulus};
			end
			rem_n = t[16:0];
		end
	end

	assign resp.done = done_q;
	assign resp.pos  = rem_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			H_IDLE: begin
				if (req.start) begin
					seed_q <= req.seed;
					v_q    <= key_lo;
					mc_q   <= bfm_pkg::MM_C1;
					ret_q  <= H_A1;
				end
			end
			H_MUL: begin
				priority case (mph_q)
					2'd0: acc_q <= prod;
					2'd1: acc_q <= acc_q + {prod[31:0], 32'd0};
					default: v_q <= acc_q + {prod[31:0], 32'd0};
				endcase
			end
			H_A1: begin
				v_q   <= bfm_pkg::rotl64(v_q, 31);
				mc_q  <= bfm_pkg::MM_C2;
				ret_q <= H_A2;
			end
			H_A2: begin
				m1_q  <= v_q;
				v_q   <= key_hi;
				mc_q  <= bfm_pkg::MM_C2;
				ret_q <= H_A3;
			end
			H_A3: begin
				v_q   <= bfm_pkg::rotl64(v_q, 33);
				mc_q  <= bfm_pkg::MM_C1;
				ret_q <= H_A4;
			end
			H_A4: begin
				m2_q <= v_q;
			end
			H_I0: begin
				if (long_key) begin
					h1_q <= bfm_pkg::rotl64(seed64 ^ m1_q, 27) + seed64;
				end else begin
					h1_q <= seed64 ^ m1_q;
					h2_q <= seed64 ^ m2_q;
				end
			end
			H_I1: h1_q <= (h1_q << 2) + h1_q + bfm_pkg::MM_ADD1;
			H_I2: h2_q <= bfm_pkg::rotl64(seed64 ^ m2_q, 31) + h1_q;
			H_I3: h2_q <= (h2_q << 2) + h2_q + bfm_pkg::MM_ADD2;
			H_F0: begin
				h1_q <= (h1_q ^ len64) + (h2_q ^ len64);
				h2_q <= h2_q ^ len64;
			end
			H_F1: begin
				h2_q  <= h2_q + h1_q;
				v_q   <= bfm_pkg::xs33(h1_q);
				mc_q  <= bfm_pkg::FMIX_1;
				ret_q <= H_F2;
			end
			H_F2: begin
				v_q   <= bfm_pkg::xs33(v_q);
				mc_q  <= bfm_pkg::FMIX_2;
				ret_q <= H_F3;
			end
			H_F3: begin
				h1_q  <= bfm_pkg::xs33(v_q);
				v_q   <= bfm_pkg::xs33(h2_q);
				mc_q  <= bfm_pkg::FMIX_1;
				ret_q <= H_F4;
			end
			H_F4: begin
				v_q   <= bfm_pkg::xs33(v_q);
				mc_q  <= bfm_pkg::FMIX_2;
				ret_q <= H_F5;
			end
			H_F5: begin
				v_q   <= h1_q + bfm_pkg::xs33(v_q);
				rem_q <= '0;
			end
			H_DIV: begin
				rem_q <= rem_n;
				v_q   <= v_q << 4;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			mph_q  <= '0;
			dcnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == H_DIV) && (dcnt_q == 4'd15);
			unique case (st_q)
				H_IDLE: begin
					if (req.start) begin
						st_q <= req.first ? H_MUL : H_I0;
					end
					mph_q <= '0;
				end
				H_MUL: begin
					if (mph_q == 2'd2) begin
						mph_q <= '0;
						st_q  <= ret_q;
					end else begin
						mph_q <= mph_q + 1'b1;
					end
				end
				H_A1, H_A2, H_A3, H_F1, H_F2, H_F3, H_F4: st_q <= H_MUL;
				H_A4: st_q <= H_I0;
				H_I0: st_q <= long_key ? H_I1 : H_F0;
				H_I1: st_q <= H_I2;
				H_I2: st_q <= H_I3;
				H_I3: st_q <= H_F0;
				H_F0: st_q <= H_F1;
				H_F5: begin
					dcnt_q <= '0;
					st_q   <= H_DIV;
				end
				H_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 4'd15) begin
						st_q <= H_IDLE;
					end
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/bfm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter back end
// Configuration, bit store, probe sequencing, counters and result words.
// ---------------------------------------------------------------------------
module bfm_back #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [bfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [bfm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                   init_busy,
	input  wire logic                              cmd_empty,
	input  wire bfm_pkg::cmd_t                     cmd,
	output logic                                   cmd_pop,
	input  wire logic                              res_full,
	output logic                                   res_push,
	output bfm_pkg::res_t                          res
);
	localparam int WORDS = (MAX_FILTER_BITS + 63) / 64;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [WW-1:0] LAST = WW'(WORDS - 1);
	localparam logic [24:0]   MAXFB = 25'(MAX_FILTER_BITS);

	localparam logic [2:0] B_INIT = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_HASH = 3'd2;
	localparam logic [2:0] B_RD   = 3'd3;
	localparam logic [2:0] B_CHK  = 3'd4;
	localparam logic [2:0] B_CLR  = 3'd5;
	localparam logic [2:0] B_DONE = 3'd6;

	logic [2:0]            st_q;
	logic [16:0]           fb_q, modulus;
	logic [4:0]            hc_q, nh, seed_q;
	logic [WW-1:0]         clr_q, word_idx, waddr;
	logic                  we;
	logic [63:0]           wdata, rdata_q;
	logic [63:0]           store_q [WORDS];
	logic [31:0]           ins_q, qry_q, ins_n, qry_n;
	logic                  ans_n, all_set_q, any_new_q, bit_set;
	logic [16:0]           pos_q;
	logic [24:0]           word_full;
	bfm_pkg::cmd_t         cur_q;
	bfm_pkg::hash_req_t    req_q;
	bfm_pkg::hash_resp_t   resp;

	always_comb begin
		if (fb_q == '0) begin
			modulus = 17'd1;
		end else if ({8'd0, fb_q} > MAXFB) begin
			modulus = 17'(MAX_FILTER_BITS);
		end else begin
			modulus = fb_q;
		end
		nh = ({1'b0, hc_q} > 6'(MAX_HASHES)) ? 5'(MAX_HASHES) : hc_q;
	end

	assign word_full = {8'd0, pos_q} >> bfm_pkg::BIT_SEL_W;
	assign word_idx  = word_full[WW-1:0];
	assign bit_set   = rdata_q[pos_q[bfm_pkg::BIT_SEL_W-1:0]];
	assign init_busy = (st_q == B_INIT);

	bfm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.key_lo (cur_q.key_lo),
		.key_hi (cur_q.key_hi),
		.key_len(cur_q.key_len),
		.modulus(modulus),
		.resp   (resp)
	);

	always_comb begin
		we    = 1'b0;
		waddr = word_idx;
		wdata = rdata_q | (64'd1 << pos_q[bfm_pkg::BIT_SEL_W-1:0]);
		if (st_q == B_INIT || st_q == B_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (st_q == B_CHK && cur_q.action != bfm_pkg::ACT_QUERY) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[word_idx];
	end

	always_comb begin
		ans_n = 1'b0;
		ins_n = ins_q;
		qry_n = qry_q;
		unique case (cur_q.action)
			bfm_pkg::ACT_INSERT: begin
				if (ins_q != 32'hffffffff) ins_n = ins_q + 1'b1;
			end
			bfm_pkg::ACT_QUERY: begin
				ans_n = all_set_q;
				if (all_set_q && qry_q != 32'hffffffff) qry_n = qry_q + 1'b1;
			end
			bfm_pkg::ACT_CHECK: begin
				ans_n = any_new_q;
				if (any_new_q && ins_q != 32'hffffffff) ins_n = ins_q + 1'b1;
			end
			default: begin
				ins_n = '0;
				qry_n = '0;
			end
		endcase
	end

	assign res_push          = (st_q == B_DONE) && !res_full;
	assign res.answer        = ans_n;
	assign res.insert_total  = ins_n;
	assign res.query_total   = qry_n;
	assign cmd_pop           = (st_q == B_IDLE) && !cmd_empty;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (st_q == B_HASH && resp.done) begin
			pos_q <= resp.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_INIT;
			fb_q      <= 17'h10000;
			hc_q      <= 5'd7;
			clr_q     <= '0;
			seed_q    <= '0;
			ins_q     <= '0;
			qry_q     <= '0;
			all_set_q <= 1'b1;
			any_new_q <= 1'b0;
			req_q     <= '0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == bfm_pkg::REG_FILTER_BITS) begin
					fb_q <= cfg_data;
				end else if (cfg_index == bfm_pkg::REG_HASH_COUNT) begin
					hc_q <= cfg_data[4:0];
				end
			end
			unique case (st_q)
				B_INIT: begin
					if (clr_q == LAST) begin
						clr_q <= '0;
						st_q  <= B_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (!cmd_empty) begin
						all_set_q <= 1'b1;
						any_new_q <= 1'b0;
						seed_q    <= '0;
						clr_q     <= '0;
						if (cmd.action == bfm_pkg::ACT_CLEAR) begin
							st_q <= B_CLR;
						end else if (nh == '0) begin
							st_q <= B_DONE;
						end else begin
							req_q <= '{start: 1'b1, first: 1'b1, seed: 5'd0};
							st_q  <= B_HASH;
						end
					end
				end
				B_HASH: begin
					req_q.start <= 1'b0;
					if (resp.done) begin
						st_q <= B_RD;
					end
				end
				B_RD: st_q <= B_CHK;
				B_CHK: begin
					if (!bit_set) begin
						all_set_q <= 1'b0;
						any_new_q <= 1'b1;
					end
					if (cur_q.action == bfm_pkg::ACT_QUERY && !bit_set) begin
						st_q <= B_DONE;
					end else if ({1'b0, seed_q} + 6'd1 == {1'b0, nh}) begin
						st_q <= B_DONE;
					end else begin
						seed_q <= seed_q + 1'b1;
						req_q  <= '{start: 1'b1, first: 1'b0, seed: seed_q + 5'd1};
						st_q   <= B_HASH;
					end
				end
				B_CLR: begin
					if (clr_q == LAST) begin
						st_q <= B_DONE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				B_DONE: begin
					if (!res_full) begin
						ins_q <= ins_n;
						qry_q <= qry_n;
						st_q  <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/bloom_filter_membership_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bloom filter membership unit
// Insert, query, insert-and-check and clear over a bit store, one result
// word per action word.
// ---------------------------------------------------------------------------
// Action words enter on push/full; result words leave on empty/pop, oldest
// first. A two-word queue sits on each side, so the input keeps taking words
// while a result waits for pop, and a stalled reader stops the back end
// once the result queue has filled.
// Each probe runs the seeded hash on one shared 32x32 multiplier (four
// products) and a four-bit-a-cycle modulo, then reads the bit store and,
// but for a query, writes the probed bit back. The first probe of a word
// also mixes the key, and a query stops at its first clear bit.
// A clear sweeps the store one 64-bit row a cycle.
// After reset the store is swept the same way, with full held high;
// configuration writes are taken throughout.
// ---------------------------------------------------------------------------
module bloom_filter_membership_unit #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16,
	parameter int MAX_KEY_BYTES   = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [1:0]                       action,
	input  wire logic [63:0]                      key_bytes_low,
	input  wire logic [63:0]                      key_bytes_high,
	input  wire logic [4:0]                       key_length,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  answer,
	output logic [31:0]                           insert_total,
	output logic [31:0]                           positive_query_total,
	input  wire logic                             cfg_write,
	input  wire logic [bfm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	logic          init_busy, cmd_empty, cmd_pop, res_full, res_push;
	bfm_pkg::cmd_t cmd;
	bfm_pkg::res_t res_in, res_out;
	logic [$bits(bfm_pkg::res_t)-1:0] res_rdata;

	bfm_front #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold          (init_busy),
		.push          (push),
		.full          (full),
		.action        (action),
		.key_bytes_low (key_bytes_low),
		.key_bytes_high(key_bytes_high),
		.key_length    (key_length),
		.cmd_pop       (cmd_pop),
		.cmd_empty     (cmd_empty),
		.cmd           (cmd)
	);

	bfm_back #(
		.MAX_FILTER_BITS(MAX_FILTER_BITS),
		.MAX_HASHES     (MAX_HASHES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.init_busy(init_busy),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	bfm_fifo #(
		.WIDTH($bits(bfm_pkg::res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out              = bfm_pkg::res_t'(res_rdata);
	assign answer               = res_out.answer;
	assign insert_total         = res_out.insert_total;
	assign positive_query_total = res_out.query_total;

endmodule
`default_nettype wire
